// ===== hw/rtl/max_collinear_points_top_assert.svh =====
// assertion macros for the collinear points block and its checker
// no dependencies; expects i_clk and i_rst_n in the scope of use
`ifndef MAX_COLLINEAR_POINTS_TOP_ASSERT_SVH
`define MAX_COLLINEAR_POINTS_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define MCP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define MCP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mcp_pkg.sv =====
// shared constants, types and helpers of the collinear points block
// no dependencies
`default_nettype none
package mcp_pkg;

    localparam int MAX_POINTS = 64;
    localparam int COORD_BITS = 16;
    localparam int ADDR_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int RESULT_W   = 7;
    localparam int POINT_W    = 2 * COORD_BITS;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } t_point;

    typedef struct packed {
        logic signed [DIFF_W-1:0] x;
        logic signed [DIFF_W-1:0] y;
    } t_diff;

    // result of one collinearity test from the cross product pipeline
    typedef struct packed {
        logic vld;
        logic hit;
    } t_hit;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ARD,
        S_ALAT,
        S_JRD,
        S_JLAT,
        S_KRUN,
        S_KDRN,
        S_CAND,
        S_DONE
    } t_state;

    // difference vector b - a, one bit wider than the coordinates
    function automatic t_diff pt_diff(input t_point b, input t_point a);
        t_diff d;
        d.x = DIFF_W'(b.x) - DIFF_W'(a.x);
        d.y = DIFF_W'(b.y) - DIFF_W'(a.y);
        return d;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/mcp_in_if.sv =====
// input channel: valid, ready and one point or finish command
// depends on mcp_pkg
`default_nettype none
interface mcp_in_if;
    import mcp_pkg::*;
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;

    modport source (output valid, mode, coord_x, coord_y, input ready);
    modport sink   (input valid, mode, coord_x, coord_y, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/mcp_out_if.sv =====
// output channel: valid, ready and one line count result
// depends on mcp_pkg
`default_nettype none
interface mcp_out_if;
    import mcp_pkg::*;
    logic                valid;
    logic                ready;
    logic [RESULT_W-1:0] max_on_line;
    logic                overflowed;

    modport source (output valid, max_on_line, overflowed, input ready);
    modport sink   (input valid, max_on_line, overflowed, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/mcp_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`default_nettype none
module mcp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                              i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/mcp_cross.sv =====
// cross product stage: tests a streamed point against the anchor and the probe direction
// depends on mcp_pkg
`default_nettype none
module mcp_cross (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_vld,
    input  wire mcp_pkg::t_point i_pt,
    input  wire mcp_pkg::t_point i_anchor,
    input  wire mcp_pkg::t_diff  i_dir,
    output mcp_pkg::t_hit        o_hit
);
    import mcp_pkg::*;

    t_diff                    dk;
    logic signed [PROD_W-1:0] r_p1;
    logic signed [PROD_W-1:0] r_p2;
    logic                     r_dup;
    logic                     r_vld;

    assign dk = pt_diff(i_pt, i_anchor);

    // products of the two cross terms
    always_ff @(posedge i_clk) begin
        r_p1  <= i_dir.x * dk.y;
        r_p2  <= i_dir.y * dk.x;
        r_dup <= (dk.x == '0) && (dk.y == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    // a copy of the anchor never joins a direction group
    assign o_hit.vld = r_vld;
    assign o_hit.hit = !r_dup && (r_p1 == r_p2);
endmodule
`default_nettype wire

// ===== hw/rtl/max_collinear_points_top.sv =====
// top level of the collinear points block: point store, pair sequencer, result register
// depends on mcp_pkg, mcp_in_if, mcp_out_if, mcp_ram, mcp_cross
//
//  channel | dir | fields                     | transaction
//  i_in    | in  | mode, coord_x, coord_y     | load one point or finish the set
//  o_out   | out | max_on_line, overflowed    | one result per finish
//
// a load writes one point into the store, or flags overflow when it is full; a finish
// scans the anchor and probe pairs up to a valid result, paced by the single read port
// of the point store that streams one point per cycle
// for each anchor and probe pair; a repeated point skips its probe scan
// reset is synchronous and empties the set; the store needs no clearing
// the result waits in its output register; a new transaction enters once it is taken

`default_nettype none
module max_collinear_points_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mcp_in_if.sink    i_in,
    mcp_out_if.source o_out
);
    import mcp_pkg::*;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_ovf, n_ovf;
    logic [CNT_W-1:0]    r_i, n_i;
    logic [CNT_W-1:0]    r_j, n_j;
    logic [CNT_W-1:0]    r_k, n_k;
    logic [CNT_W-1:0]    r_dup, n_dup;
    logic [CNT_W-1:0]    r_top, n_top;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [CNT_W-1:0]    r_best, n_best;
    logic                r_rd_vld, n_rd_vld;
    t_point              r_anchor, n_anchor;
    t_diff               r_dir, n_dir;
    logic                r_out_vld, n_out_vld;
    logic [RESULT_W-1:0] r_out_max, n_out_max;
    logic                r_out_ovf, n_out_ovf;

    logic                in_acc;
    logic                we;
    logic [ADDR_W-1:0]   raddr;
    t_point              wpt;
    t_point              rpt;
    t_diff               dj;
    t_hit                hit;
    logic [CNT_W-1:0]    cand;

    assign i_in.ready  = (r_state == S_IDLE) && (!r_out_vld || o_out.ready);
    assign in_acc      = i_in.valid && i_in.ready;
    assign wpt.x       = i_in.coord_x;
    assign wpt.y       = i_in.coord_y;
    assign dj          = pt_diff(rpt, r_anchor);
    assign cand        = r_top + r_dup + CNT_W'(1);

    assign o_out.valid       = r_out_vld;
    assign o_out.max_on_line = r_out_max;
    assign o_out.overflowed  = r_out_ovf;

    // point store
    mcp_ram #(
        .WIDTH (POINT_W),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (wpt),
        .i_raddr (raddr),
        .o_rdata (rpt)
    );

    mcp_cross u_cross (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (r_rd_vld),
        .i_pt     (rpt),
        .i_anchor (r_anchor),
        .i_dir    (r_dir),
        .o_hit    (hit)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && i_in.mode) begin
                    n_state = (r_count == '0) ? S_DONE : S_ARD;
                end
            end
            S_ARD:  n_state = S_ALAT;
            S_ALAT: n_state = (r_i + CNT_W'(1) >= r_count) ? S_CAND : S_JRD;
            S_JRD:  n_state = S_JLAT;
            S_JLAT: begin
                if (dj.x == '0 && dj.y == '0) begin
                    n_state = (r_j + CNT_W'(1) >= r_count) ? S_CAND : S_JRD;
                end else begin
                    n_state = S_KRUN;
                end
            end
            S_KRUN: begin
                if (r_k == r_count - CNT_W'(1)) begin
                    n_state = S_KDRN;
                end
            end
            S_KDRN: begin
                if (!r_rd_vld && !hit.vld) begin
                    n_state = (r_j + CNT_W'(1) >= r_count) ? S_CAND : S_JRD;
                end
            end
            S_CAND: n_state = (r_i + CNT_W'(1) >= r_count) ? S_DONE : S_ARD;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_count   = r_count;
        n_ovf     = r_ovf;
        n_i       = r_i;
        n_j       = r_j;
        n_k       = r_k;
        n_dup     = r_dup;
        n_top     = r_top;
        n_cnt     = r_cnt;
        n_best    = r_best;
        n_rd_vld  = 1'b0;
        n_anchor  = r_anchor;
        n_dir     = r_dir;
        n_out_vld = r_out_vld;
        n_out_max = r_out_max;
        n_out_ovf = r_out_ovf;
        we        = 1'b0;
        raddr     = r_i[ADDR_W-1:0];

        if (r_out_vld && o_out.ready) begin
            n_out_vld = 1'b0;
        end
        if (hit.vld && hit.hit) begin
            n_cnt = r_cnt + CNT_W'(1);
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc && !i_in.mode) begin
                    if (r_count < CNT_W'(MAX_POINTS)) begin
                        we      = 1'b1;
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
                if (in_acc && i_in.mode) begin
                    n_i    = '0;
                    n_best = '0;
                end
            end
            S_ARD: begin
                raddr = r_i[ADDR_W-1:0];
            end
            S_ALAT: begin
                n_anchor = rpt;
                n_j      = r_i + CNT_W'(1);
                n_dup    = '0;
                n_top    = '0;
            end
            S_JRD: begin
                raddr = r_j[ADDR_W-1:0];
            end
            S_JLAT: begin
                if (dj.x == '0 && dj.y == '0) begin
                    n_dup = r_dup + CNT_W'(1);
                    n_j   = r_j + CNT_W'(1);
                end else begin
                    n_dir = dj;
                    n_k   = r_j;
                    n_cnt = '0;
                end
            end
            S_KRUN: begin
                raddr    = r_k[ADDR_W-1:0];
                n_rd_vld = 1'b1;
                n_k      = r_k + CNT_W'(1);
            end
            S_KDRN: begin
                if (!r_rd_vld && !hit.vld) begin
                    if (r_cnt > r_top) begin
                        n_top = r_cnt;
                    end
                    n_j = r_j + CNT_W'(1);
                end
            end
            S_CAND: begin
                if (cand > r_best) begin
                    n_best = cand;
                end
                n_i = r_i + CNT_W'(1);
            end
            S_DONE: begin
                n_out_vld = 1'b1;
                n_out_max = RESULT_W'(r_best);
                n_out_ovf = r_ovf;
                n_count   = '0;
                n_ovf     = 1'b0;
            end
            default: begin
                n_rd_vld = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_best    <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_ovf     <= n_ovf;
            r_best    <= n_best;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_i       <= n_i;
        r_j       <= n_j;
        r_k       <= n_k;
        r_dup     <= n_dup;
        r_top     <= n_top;
        r_cnt     <= n_cnt;
        r_anchor  <= n_anchor;
        r_dir     <= n_dir;
        r_out_max <= n_out_max;
        r_out_ovf <= n_out_ovf;
    end
endmodule
`default_nettype wire

// ===== hw/rtl/mcp_checker.sv =====
// port checker for the collinear points block, attached by bind
// depends on mcp_pkg and max_collinear_points_top_assert.svh
`default_nettype none
`include "max_collinear_points_top_assert.svh"
module mcp_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_valid,
    input wire logic                         i_in_ready,
    input wire logic                         i_in_mode,
    input wire logic                         i_out_valid,
    input wire logic                         i_out_ready,
    input wire logic [mcp_pkg::RESULT_W-1:0] i_out_max
);
    import mcp_pkg::*;

    // a stalled result holds
    `MCP_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_max), "result dropped or changed while stalled")

    // the count never exceeds the store size
    `MCP_ASSERT_IMP(a_max_range, i_out_valid, i_out_max <= RESULT_W'(MAX_POINTS), "line count above capacity")

    // a finish transaction makes the block busy
    `MCP_ASSERT_NXT(a_finish_busy, i_in_valid && i_in_ready && i_in_mode, !i_in_ready, "input taken right after finish")
endmodule

bind max_collinear_points_top mcp_checker u_mcp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_mode   (i_in.mode),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_max   (o_out.max_on_line)
);
`default_nettype wire

// ===== tb/max_collinear_points_top_tb.sv =====
// self-checking testbench for max_collinear_points_top: point sets in, line counts out
// depends on mcp_pkg, mcp_in_if, mcp_out_if and the block's rtl
`default_nettype none
module max_collinear_points_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mcp_pkg::*;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_FINISH = 1'b1;
    localparam int   RX_HOLD     = 3000;

    typedef struct {
        logic                  mode;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } t_cmd;

    typedef struct {
        logic [RESULT_W-1:0] count;
        logic                ovf;
    } t_line_result;

    logic i_clk;
    logic i_rst_n;

    mcp_in_if  in_ch();
    mcp_out_if out_ch();

    max_collinear_points_top dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    t_cmd         cmd_queue[$];
    t_line_result line_queue[$];

    // shadow copy of the loaded set
    longint set_x[MAX_POINTS];
    longint set_y[MAX_POINTS];
    int     set_len;
    bit     set_dropped;

    int errors;
    int accepted_cmds;
    bit stim_done;

    // clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // largest number of stored points sharing one line
    function automatic int best_collinear();
        int best;
        int top;
        int dup;
        int grp;
        longint dxj, dyj, dxk, dyk;
        best = 0;
        for (int i = 0; i < set_len; i++) begin
            top = 0;
            dup = 0;
            for (int j = i + 1; j < set_len; j++) begin
                dxj = set_x[j] - set_x[i];
                dyj = set_y[j] - set_y[i];
                if (dxj == 0 && dyj == 0) begin
                    dup++;
                end else begin
                    // points after the anchor on the same line through it
                    grp = 0;
                    for (int k = i + 1; k < set_len; k++) begin
                        dxk = set_x[k] - set_x[i];
                        dyk = set_y[k] - set_y[i];
                        if (!(dxk == 0 && dyk == 0) && dxj * dyk == dyj * dxk)
                            grp++;
                    end
                    if (grp > top)
                        top = grp;
                end
            end
            if (top + dup + 1 > best)
                best = top + dup + 1;
        end
        return best;
    endfunction

    task automatic push_cmd(input logic mode, input int x, input int y);
        t_cmd c;
        c.mode = mode;
        c.x    = x[COORD_BITS-1:0];
        c.y    = y[COORD_BITS-1:0];
        cmd_queue.insert(cmd_queue.size(), c);
    endtask

    task automatic push_finish();
        push_cmd(MODE_FINISH, $urandom, $urandom);
    endtask

    // one random set; style picks wide, clustered or line-heavy points
    task automatic push_set(input int n, input int style);
        int bx, by, ddx, ddy, t;
        bx  = $urandom_range(0, 2000) - 1000;
        by  = $urandom_range(0, 2000) - 1000;
        ddx = $urandom_range(0, 40) - 20;
        ddy = $urandom_range(0, 40) - 20;
        for (int p = 0; p < n; p++) begin
            case (style)
                0: begin
                    push_cmd(MODE_LOAD, $urandom, $urandom);
                end
                1: begin
                    push_cmd(MODE_LOAD, $urandom_range(0, 6) - 3, $urandom_range(0, 6) - 3);
                end
                default: begin
                    t = $urandom_range(0, 80) - 40;
                    if ($urandom_range(0, 4) == 0)
                        push_cmd(MODE_LOAD, bx + $urandom_range(0, 50),
                                 by - $urandom_range(0, 50));
                    else
                        push_cmd(MODE_LOAD, bx + t * ddx, by + t * ddy);
                end
            endcase
        end
        push_finish();
    endtask

    // stimulus
    initial begin
        int big_sets;
        errors    = 0;
        stim_done = 1'b0;

        // empty set, single point, extremes and opposite corners
        push_finish();
        push_cmd(MODE_LOAD, 5, -7);
        push_finish();
        push_cmd(MODE_LOAD, -32768, -32768);
        push_cmd(MODE_LOAD, 32767, 32767);
        push_cmd(MODE_LOAD, 0, -1);
        push_cmd(MODE_LOAD, -32768, 32767);
        push_cmd(MODE_LOAD, 32767, -32768);
        push_finish();
        // duplicates, vertical and horizontal lines, opposite directions
        push_cmd(MODE_LOAD, 3, 3);
        push_cmd(MODE_LOAD, 3, 3);
        push_cmd(MODE_LOAD, 3, 9);
        push_cmd(MODE_LOAD, 3, -4);
        push_cmd(MODE_LOAD, 8, 3);
        push_cmd(MODE_LOAD, -2, 3);
        push_cmd(MODE_LOAD, 3, 3);
        push_cmd(MODE_LOAD, 5, 5);
        push_cmd(MODE_LOAD, 1, 1);
        push_finish();
        // only duplicates
        push_cmd(MODE_LOAD, -1, 0);
        push_cmd(MODE_LOAD, -1, 0);
        push_cmd(MODE_LOAD, -1, 0);
        push_finish();

        // random sets, mostly small, a few near or past capacity
        big_sets = 0;
        while (cmd_queue.size() < 1600) begin
            if (big_sets < 3 && $urandom_range(0, 40) == 0) begin
                big_sets++;
                push_set($urandom_range(MAX_POINTS - 2, MAX_POINTS + 6), $urandom_range(0, 2));
            end else begin
                push_set($urandom_range(0, 12), $urandom_range(0, 2));
            end
        end
        if (big_sets == 0)
            push_set(MAX_POINTS + 3, 2);
        stim_done = 1'b1;
    end

    // reset and input driver: bursts with random gaps
    int burst_left;
    int gap_left;
    bit in_taken;

    initial begin
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.mode     = MODE_LOAD;
        in_ch.coord_x  = '0;
        in_ch.coord_y  = '0;
        out_ch.ready   = 1'b0;
        burst_left     = 0;
        gap_left       = 0;
        in_taken       = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(negedge i_clk) begin
        t_cmd c;
        if (i_rst_n && !(in_ch.valid && !in_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                in_ch.valid <= 1'b0;
            end else if (cmd_queue.size() > 0) begin
                c = cmd_queue.pop_front();
                in_ch.valid   <= 1'b1;
                in_ch.mode    <= c.mode;
                in_ch.coord_x <= c.x;
                in_ch.coord_y <= c.y;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 20);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern with one long hold-off
    int stall_mode;
    int stall_left;
    int hold_left;
    bit hold_done;

    initial begin
        stall_mode = 0;
        stall_left = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!hold_done && accepted_cmds >= 300) begin
                hold_done = 1'b1;
                hold_left = RX_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                if (stall_left == 0) begin
                    stall_mode = $urandom_range(0, 2);
                    stall_left = $urandom_range(20, 200);
                end else begin
                    stall_left--;
                end
                case (stall_mode)
                    0:       out_ch.ready <= 1'b1;
                    1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
                    default: out_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // input monitor: track the set and predict results
    initial begin
        accepted_cmds = 0;
        set_len       = 0;
        set_dropped   = 1'b0;
    end

    always @(posedge i_clk) begin
        t_line_result r;
        in_taken = 1'b0;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            in_taken = 1'b1;
            accepted_cmds++;
            if (in_ch.mode == MODE_LOAD) begin
                if (set_len < MAX_POINTS) begin
                    set_x[set_len] = longint'(in_ch.coord_x);
                    set_y[set_len] = longint'(in_ch.coord_y);
                    set_len++;
                end else begin
                    set_dropped = 1'b1;
                end
            end else begin
                r.count = RESULT_W'(best_collinear());
                r.ovf   = set_dropped;
                line_queue.insert(line_queue.size(), r);
                set_len     = 0;
                set_dropped = 1'b0;
            end
        end
    end

    // output monitor: compare against the oldest prediction
    always @(posedge i_clk) begin
        t_line_result e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (line_queue.size() == 0) begin
                $error("unexpected result transaction: max_on_line %0d overflowed %0b",
                       out_ch.max_on_line, out_ch.overflowed);
                errors++;
            end else begin
                e = line_queue.pop_front();
                if (out_ch.max_on_line !== e.count) begin
                    $error("max_on_line: expected %0d actual %0d", e.count, out_ch.max_on_line);
                    errors++;
                end
                if (out_ch.overflowed !== e.ovf) begin
                    $error("overflowed: expected %0b actual %0b", e.ovf, out_ch.overflowed);
                    errors++;
                end
            end
        end
    end

    // end of run
    initial begin
        wait (stim_done);
        wait (cmd_queue.size() == 0 && !in_ch.valid);
        wait (line_queue.size() == 0);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && line_queue.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // timeout
    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/mcp_pkg.sv
hw/rtl/mcp_in_if.sv
hw/rtl/mcp_out_if.sv
hw/rtl/mcp_ram.sv
hw/rtl/mcp_cross.sv
hw/rtl/max_collinear_points_top.sv
hw/rtl/mcp_checker.sv
tb/max_collinear_points_top_tb.sv
